[rtl/afds_pkg.sv]
// Package for the alternating factorial divisor scan.
// Holds field widths, defaults, controller states and the
// command/status structs shared by the controller and datapath.
`timescale 1ns / 1ps

package afds_pkg;

  // Fixed field widths
  localparam int PRIME_W = 52;
  localparam int MAXN_W  = 20;

  // Parameter defaults
  localparam int DEF_PRIME_BITS  = 52;
  localparam int DEF_MAX_REPORTS = 64;

  // Limit register value after reset
  localparam logic [MAXN_W-1:0] MAXN_RESET = 20'd1000;

  // One multiplier bit per cycle over the term index
  localparam int MUL_STEPS = MAXN_W;
  localparam int STEP_W    = $clog2(MUL_STEPS);
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(MUL_STEPS - 1);

  // Controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_INIT  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_FINAL = 6'b010000,
    ST_SPARE = 6'b100000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture divisor, reset residues and counters
    logic mul_start;  // clear accumulator, point at top multiplier bit
    logic mul_step;   // one shift-add-reduce step
    logic commit;     // take product, record hit, step n
    logic set_trunc;  // report cap hit: flag truncation
    logic final_load; // load the closing result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;       // zero divisor or limit below two
    logic mul_last;   // current step is the lowest multiplier bit
    logic hit;        // product equals previous alternating residue
    logic cnt_full;   // report cap reached
    logic pend_v;     // a report is held back
    logic stop;       // scan ends after this term
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

[rtl/afds_ctrl.sv]
// Controller for the alternating factorial divisor scan.
// Sequences load, per-term multiply, check and final report.
// Depends on afds_pkg.
`timescale 1ns / 1ps

module afds_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  afds_pkg::sts_t sts,
  output afds_pkg::cmd_t cmd
);

  afds_pkg::state_t state_r, state_nxt;

  // Input is taken only between scans
  assign in_stall = (state_r != afds_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      afds_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = afds_pkg::ST_INIT;
        end
      end
      afds_pkg::ST_INIT: begin
        if (sts.skip) begin
          state_nxt = afds_pkg::ST_FINAL;
        end else begin
          cmd.mul_start = 1'b1;
          state_nxt     = afds_pkg::ST_MUL;
        end
      end
      afds_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = afds_pkg::ST_CHECK;
      end
      afds_pkg::ST_CHECK: begin
        if (sts.hit && sts.cnt_full) begin
          cmd.set_trunc = 1'b1;
          state_nxt     = afds_pkg::ST_FINAL;
        end else if (sts.hit && sts.pend_v && !sts.out_free) begin
          // wait for room to release the held report
          state_nxt = afds_pkg::ST_CHECK;
        end else begin
          cmd.commit    = 1'b1;
          cmd.mul_start = 1'b1;
          state_nxt     = sts.stop ? afds_pkg::ST_FINAL : afds_pkg::ST_MUL;
        end
      end
      afds_pkg::ST_FINAL: begin
        if (sts.out_free) begin
          cmd.final_load = 1'b1;
          state_nxt      = afds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = afds_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= afds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/afds_dp.sv]
// Datapath for the alternating factorial divisor scan.
// Residues, bit-serial modular multiplier, report bookkeeping, output register.
// Depends on afds_pkg.
`timescale 1ns / 1ps

module afds_dp #(
  parameter int PRIME_BITS  = afds_pkg::DEF_PRIME_BITS,
  parameter int MAX_REPORTS = afds_pkg::DEF_MAX_REPORTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [afds_pkg::PRIME_W-1:0]  in_prime,
  input  logic [afds_pkg::MAXN_W-1:0]   max_n,
  input  afds_pkg::cmd_t                cmd,
  output afds_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [afds_pkg::MAXN_W-1:0]   out_term_index,
  output logic [afds_pkg::PRIME_W-1:0]  out_divisor,
  output logic                          out_truncated,
  output logic                          out_last
);

  localparam int PB    = PRIME_BITS;
  localparam int CNT_W = $clog2(MAX_REPORTS + 1);
  localparam int NW    = afds_pkg::MAXN_W;
  localparam int SW    = afds_pkg::STEP_W;

  logic [PB-1:0]                p_r, fact_r, prev_r, acc_r;
  logic [PB-1:0]                acc_nxt, prev_nxt, p_in;
  logic [NW-1:0]                n_r, pend_n_r;
  logic [SW-1:0]                step_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         pend_v_r, trunc_r;
  logic                         out_valid_r, out_found_r, out_trunc_r, out_last_r;
  logic [NW-1:0]                out_term_r;
  logic [afds_pkg::PRIME_W-1:0] out_div_r;

  logic [63:0]                  in_ext, p_ext;
  logic [PB:0]                  dbl, dbl_sub, sum, sum_sub;
  logic [PB-1:0]                dbl_red;
  logic                         hit, out_free;

  // Divisor masked to PRIME_BITS, echoed at the fixed field width
  assign in_ext = 64'(in_prime);
  assign p_in   = in_ext[PB-1:0];
  assign p_ext  = 64'(p_r);

  // One multiplier step: acc = 2*acc (+ fact) mod p
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_sub = dbl - {1'b0, p_r};
    dbl_red = (dbl >= {1'b0, p_r}) ? dbl_sub[PB-1:0] : dbl[PB-1:0];
    sum     = {1'b0, dbl_red} + {1'b0, fact_r};
    sum_sub = sum - {1'b0, p_r};
    if (n_r[step_r]) begin
      acc_nxt = (sum >= {1'b0, p_r}) ? sum_sub[PB-1:0] : sum[PB-1:0];
    end else begin
      acc_nxt = dbl_red;
    end
  end

  // Next alternating residue: fact - prev mod p
  always_comb begin
    if (acc_r >= prev_r) begin
      prev_nxt = acc_r - prev_r;
    end else begin
      prev_nxt = acc_r + (p_r - prev_r);
    end
  end

  assign hit      = (acc_r == prev_r);
  assign out_free = !out_valid_r || !out_stall;

  // Status to the controller
  always_comb begin
    sts.skip     = (p_r == '0) || (max_n < NW'(2));
    sts.mul_last = (step_r == '0);
    sts.hit      = hit;
    sts.cnt_full = (cnt_r == CNT_W'(MAX_REPORTS));
    sts.pend_v   = pend_v_r;
    sts.stop     = ((acc_r == '0) && (prev_nxt != '0)) || (n_r == max_n);
    sts.out_free = out_free;
  end

  // Residues and multiplier
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r    <= p_in;
      fact_r <= (p_in == PB'(1)) ? '0 : PB'(1);
      prev_r <= (p_in == PB'(1)) ? '0 : PB'(1);
      n_r    <= NW'(2);
    end
    if (cmd.mul_start) begin
      acc_r  <= '0;
      step_r <= afds_pkg::STEP_FIRST;
    end else if (cmd.mul_step) begin
      acc_r  <= acc_nxt;
      step_r <= step_r - SW'(1);
    end
    if (cmd.commit) begin
      fact_r <= acc_r;
      prev_r <= prev_nxt;
      n_r    <= n_r + NW'(1);
      if (hit) pend_n_r <= n_r;
    end
  end

  // Report bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      trunc_r  <= 1'b0;
    end else if (cmd.load) begin
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      trunc_r  <= 1'b0;
    end else begin
      if (cmd.commit && hit) begin
        cnt_r    <= cnt_r + CNT_W'(1);
        pend_v_r <= 1'b1;
      end
      if (cmd.set_trunc) trunc_r <= 1'b1;
    end
  end

  // Output register: held report on a new hit, closing result at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && hit && pend_v_r) begin
      out_valid_r <= 1'b1;
    end else if (cmd.final_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Divisor is held with the result, since the next request reloads p_r
  always_ff @(posedge clk) begin
    if (cmd.commit && hit && pend_v_r) begin
      out_found_r <= 1'b1;
      out_term_r  <= pend_n_r;
      out_div_r   <= p_ext[afds_pkg::PRIME_W-1:0];
      out_trunc_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (cmd.final_load) begin
      out_found_r <= pend_v_r;
      out_term_r  <= pend_v_r ? pend_n_r : '0;
      out_div_r   <= p_ext[afds_pkg::PRIME_W-1:0];
      out_trunc_r <= pend_v_r && trunc_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_term_index = out_term_r;
  assign out_divisor    = out_div_r;
  assign out_truncated  = out_trunc_r;
  assign out_last       = out_last_r;

endmodule

[rtl/alternating_factorial_divisor_scan.sv]
// Alternating factorial divisor scan: one divisor in, a list of hits out.
// Instantiates afds_ctrl and afds_dp; depends on afds_pkg.
//
// Usage:
//   Input channel in_valid/in_stall/in_prime: one divisor p per request.
//   Output channel out_valid/out_stall plus out_found, out_term_index,
//   out_divisor, out_truncated, out_last: one result per hit n (p divides
//   af(n)), up to MAX_REPORTS; out_last marks the final result of a divisor,
//   and a divisor without hits gives a single result with out_found low.
//   Config channel cfg_valid/cfg_ready/cfg_max_n sets the scan limit; write
//   it only while the block is idle. cfg_ready is always high.
// Timing:
//   Each term n takes 20 shift-add-reduce steps of the bit-serial modular
//   multiplier (one per bit of n) and then a check, which waits while a
//   held report finds the output register full. The scan may end before
//   max_n is reached. One divisor is scanned at a time; in_stall is
//   high from acceptance until the final result sits in the output register.
// Reset: rst_n is synchronous, clears the controller and output valid and
//   sets the limit to 1000. A stalled output holds its result; the scan
//   pauses when the next result finds the output register still full.
`timescale 1ns / 1ps

module alternating_factorial_divisor_scan #(
  parameter int PRIME_BITS  = afds_pkg::DEF_PRIME_BITS,
  parameter int MAX_REPORTS = afds_pkg::DEF_MAX_REPORTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [afds_pkg::PRIME_W-1:0]  in_prime,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [afds_pkg::MAXN_W-1:0]   out_term_index,
  output logic [afds_pkg::PRIME_W-1:0]  out_divisor,
  output logic                          out_truncated,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [afds_pkg::MAXN_W-1:0]   cfg_max_n
);

  afds_pkg::cmd_t              cmd;
  afds_pkg::sts_t              sts;
  logic [afds_pkg::MAXN_W-1:0] max_n_r;

  // Scan limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_n_r <= afds_pkg::MAXN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_n_r <= cfg_max_n;
    end
  end

  afds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  afds_dp #(
    .PRIME_BITS  (PRIME_BITS),
    .MAX_REPORTS (MAX_REPORTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_prime       (in_prime),
    .max_n          (max_n_r),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_term_index (out_term_index),
    .out_divisor    (out_divisor),
    .out_truncated  (out_truncated),
    .out_last       (out_last)
  );

endmodule
